// ----- rtl/light_dimmer_fade_controller_assert.svh -----
// Assertion macros for the dimmer fade controller.
// Used by the control and divider modules; no other dependencies.
`ifndef LIGHT_DIMMER_FADE_CONTROLLER_ASSERT_SVH
`define LIGHT_DIMMER_FADE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define LDF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lbl failed");
`define LDF_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`else
`define LDF_ASSERT(lbl, clk, rst, prop)
`define LDF_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ----- rtl/ldf_pkg.sv -----
// Shared types and constants for the dimmer fade controller.
// No dependencies.
package ldf_pkg;
  localparam logic [6:0] RESET_LEVEL = 7'd0;
  localparam logic [6:0] LVL_MAX = 7'd100;
  localparam logic [31:0] FADE_MIN = 32'd15;
  localparam logic [31:0] FADE_MAX = 32'd86400000;
  localparam int DIV_W = 40;

  localparam logic [3:0] REQ_TICK = 4'd0;
  localparam logic [3:0] REQ_SET = 4'd1;
  localparam logic [3:0] REQ_ON = 4'd2;
  localparam logic [3:0] REQ_LAST = 4'd3;
  localparam logic [3:0] REQ_OFF = 4'd4;
  localparam logic [3:0] REQ_TOGGLE = 4'd5;
  localparam logic [3:0] REQ_TOGGLE_ON = 4'd6;
  localparam logic [3:0] REQ_START = 4'd7;
  localparam logic [3:0] REQ_STOP = 4'd8;

  typedef logic [DIV_W-1:0] div_word_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  level;
    logic        three_state;
    logic [31:0] fade_duration;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [6:0] level_out;
    logic       is_on;
    logic       is_fading;
    logic [6:0] fade_progress;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CMD, ST_IVDIV, ST_MAGMUL, ST_MAGDIV, ST_PROGGO, ST_PROGDIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;
endpackage

// ----- rtl/ldf_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on ldf_pkg and the assertion header.
`include "light_dimmer_fade_controller_assert.svh"
module ldf_divider (
  input  logic             clk,
  input  logic             rst,
  input  ldf_pkg::div_req_t req,
  output ldf_pkg::div_rsp_t rsp
);
  localparam int CW = $clog2(ldf_pkg::DIV_W + 1);
  logic [ldf_pkg::DIV_W-1:0] quo, den, rem;
  logic [CW-1:0] cnt;
  logic busy, done;
  logic [ldf_pkg::DIV_W:0] shifted, trial;

  always_comb begin
    shifted = {rem, quo[ldf_pkg::DIV_W-1]};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CW'(ldf_pkg::DIV_W);
        quo <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        if (!trial[ldf_pkg::DIV_W]) begin
          rem <= trial[ldf_pkg::DIV_W-1:0];
          quo <= {quo[ldf_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[ldf_pkg::DIV_W-1:0];
          quo <= {quo[ldf_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;

  `LDF_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy))
  `LDF_ASSERT(a_no_start_busy, clk, rst, req.start |-> !busy)
  `LDF_ASSERT(a_done_one, clk, rst, done |=> !done)
endmodule

// ----- rtl/light_dimmer_fade_controller.sv -----
// Dimmer fade controller top level: command sequencer plus shared divider.
// Depends on ldf_pkg, ldf_divider and the assertion header.
//
// Usage: one input item (req_type, level, three_state, fade_duration, now_ms)
// on the in channel yields exactly one out item with the level, on flag, fade
// flag and fade progress. in_stall is high while an item is being worked on.
// From acceptance, an item passes through CMD, then PROGGO and OUT. A running
// fade adds a progress division, start_fade adds an interval division and a fade
// step adds a multiply step (MAGMUL) and a division. The longest path is a fade
// step with progress. The IDLE state lies between one item's output and the next
// acceptance, so no new item is taken before the last one is through. The one
// serial divider, one quotient bit per cycle, is shared by all three divisions.
// The result waits in an output register while out_stall is high; the next
// item is accepted only when that register has been taken.
// Reset clears level to RESET_LEVEL, remembered level to 50 and stops any fade.
`include "light_dimmer_fade_controller_assert.svh"
module light_dimmer_fade_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ldf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ldf_pkg::out_item_t out_data
);
  ldf_pkg::state_t state, state_next;
  ldf_pkg::in_item_t item;
  logic [6:0] cur, remb, fstart, ftarget;
  logic [26:0] fremain, stepiv;
  logic [31:0] last_t;
  logic [34:0] prod;
  logic [6:0] prog;
  ldf_pkg::div_req_t dreq;
  ldf_pkg::div_rsp_t drsp;
  logic [31:0] elapsed, durc;
  logic [6:0] lvlc, diff, dmag, pnum, pden, sw, stepv;
  logic fading, down, progneg, tick_go, tick_end, fade_go, tick_step;

  ldf_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // combinational command decode
  always_comb begin
    fading = fremain != '0;
    elapsed = item.now_ms - last_t;
    lvlc = (item.level > {1'b0, ldf_pkg::LVL_MAX}) ? ldf_pkg::LVL_MAX : item.level[6:0];
    durc = (item.fade_duration > ldf_pkg::FADE_MAX) ? ldf_pkg::FADE_MAX
                                                     : item.fade_duration;
    diff = (cur > lvlc) ? cur - lvlc : lvlc - cur;
    if (diff == '0) diff = 7'd1;
    down = ftarget < cur;
    dmag = down ? cur - ftarget : ftarget - cur;
    tick_go = fading && (elapsed >= {5'd0, stepiv});
    tick_end = elapsed >= {5'd0, fremain};
    fade_go = item.req_type == ldf_pkg::REQ_START && durc >= ldf_pkg::FADE_MIN;
    tick_step = item.req_type == ldf_pkg::REQ_TICK && tick_go && !tick_end;
    progneg = (cur < fstart) != (ftarget < fstart);
    pnum = (cur > fstart) ? cur - fstart : fstart - cur;
    pden = (ftarget > fstart) ? ftarget - fstart : fstart - ftarget;
  end

  always_comb begin
    state_next = state;
    case (state)
      ldf_pkg::ST_IDLE: if (in_valid) state_next = ldf_pkg::ST_CMD;
      ldf_pkg::ST_CMD: begin
        if (fade_go) state_next = ldf_pkg::ST_IVDIV;
        else if (tick_step) state_next = ldf_pkg::ST_MAGMUL;
        else state_next = ldf_pkg::ST_PROGGO;
      end
      ldf_pkg::ST_IVDIV: if (drsp.done) state_next = ldf_pkg::ST_PROGGO;
      ldf_pkg::ST_MAGMUL: state_next = ldf_pkg::ST_MAGDIV;
      ldf_pkg::ST_MAGDIV: if (drsp.done) state_next = ldf_pkg::ST_PROGGO;
      ldf_pkg::ST_PROGGO: begin
        if (!fading || fstart == ftarget) state_next = ldf_pkg::ST_OUT;
        else state_next = ldf_pkg::ST_PROGDIV;
      end
      ldf_pkg::ST_PROGDIV: if (drsp.done) state_next = ldf_pkg::ST_OUT;
      ldf_pkg::ST_OUT: if (!out_stall) state_next = ldf_pkg::ST_IDLE;
      default: state_next = ldf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dreq = '0;
    case (state)
      ldf_pkg::ST_CMD: begin
        if (fade_go) begin
          dreq.start = 1'b1;
          dreq.num = {7'd0, durc, 1'b0} + ldf_pkg::div_word_t'(diff);
          dreq.den = ldf_pkg::div_word_t'({diff, 1'b0});
        end
      end
      ldf_pkg::ST_MAGMUL: begin
        dreq.start = 1'b1;
        dreq.num = ldf_pkg::div_word_t'(prod) + ldf_pkg::div_word_t'(fremain);
        dreq.den = ldf_pkg::div_word_t'({fremain, 1'b0});
      end
      ldf_pkg::ST_PROGGO: begin
        if (fading && fstart != ftarget) begin
          // pnum * 100 as shifts
          dreq.start = 1'b1;
          dreq.num = ldf_pkg::div_word_t'({pnum, 7'd0}) - ldf_pkg::div_word_t'({pnum, 5'd0})
                     + ldf_pkg::div_word_t'({pnum, 2'd0});
          dreq.den = ldf_pkg::div_word_t'(pden);
        end
      end
      default: ;
    endcase
  end

  // level update helper: remembers mid levels left while not fading
  function automatic logic [6:0] remnext(input logic [6:0] v, input logic [6:0] c,
                                         input logic [6:0] r, input logic f);
    logic [6:0] res;
    res = r;
    if (v != c && !f && c != '0 && c < ldf_pkg::LVL_MAX) res = c;
    return res;
  endfunction

  always_comb begin
    case (item.req_type)
      ldf_pkg::REQ_ON: sw = ldf_pkg::LVL_MAX;
      ldf_pkg::REQ_LAST: sw = remb;
      ldf_pkg::REQ_OFF: sw = '0;
      ldf_pkg::REQ_TOGGLE: begin
        if (cur == ldf_pkg::LVL_MAX || (cur != '0 && !item.three_state)) sw = '0;
        else if (cur == '0 && item.three_state) sw = remb;
        else sw = ldf_pkg::LVL_MAX;
      end
      ldf_pkg::REQ_TOGGLE_ON: sw = (cur == ldf_pkg::LVL_MAX) ? remb : ldf_pkg::LVL_MAX;
      default: sw = cur;
    endcase
  end

  always_comb begin
    stepv = down ? cur - drsp.quo[6:0] : cur + drsp.quo[6:0];
    if (stepv > ldf_pkg::LVL_MAX) stepv = ldf_pkg::LVL_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldf_pkg::ST_IDLE;
      cur <= ldf_pkg::RESET_LEVEL;
      remb <= 7'd50;
      fstart <= ldf_pkg::RESET_LEVEL;
      ftarget <= ldf_pkg::RESET_LEVEL;
      fremain <= '0;
      stepiv <= '0;
      last_t <= '0;
    end else begin
      state <= state_next;
      if (state == ldf_pkg::ST_IDLE && in_valid) item <= in_data;
      if (state == ldf_pkg::ST_CMD) begin
        case (item.req_type)
          ldf_pkg::REQ_TICK: begin
            if (tick_go && tick_end) begin
              fremain <= '0;
              remb <= remnext(ftarget, cur, remb, 1'b0);
              cur <= ftarget;
            end
          end
          ldf_pkg::REQ_SET: begin
            remb <= remnext(lvlc, cur, remb, fading);
            cur <= lvlc;
          end
          ldf_pkg::REQ_ON, ldf_pkg::REQ_LAST, ldf_pkg::REQ_OFF,
          ldf_pkg::REQ_TOGGLE, ldf_pkg::REQ_TOGGLE_ON: begin
            remb <= remnext(sw, cur, remb, fading);
            cur <= sw;
            fremain <= '0;
          end
          ldf_pkg::REQ_START: begin
            if (fade_go) begin
              fremain <= durc[26:0];
              fstart <= cur;
              ftarget <= lvlc;
              last_t <= item.now_ms;
            end
          end
          ldf_pkg::REQ_STOP: fremain <= '0;
          default: ;
        endcase
        prod <= 35'({dmag, 1'b0}) * 35'(elapsed[26:0]);
      end
      if (state == ldf_pkg::ST_IVDIV && drsp.done)
        stepiv <= (drsp.quo < ldf_pkg::div_word_t'(ldf_pkg::FADE_MIN))
                  ? 27'(ldf_pkg::FADE_MIN) : drsp.quo[26:0];
      if (state == ldf_pkg::ST_MAGDIV && drsp.done) begin
        remb <= remnext(stepv, cur, remb, 1'b1);
        cur <= stepv;
        fremain <= fremain - elapsed[26:0];
        last_t <= item.now_ms;
      end
      if (state == ldf_pkg::ST_PROGGO && (!fading || fstart == ftarget))
        prog <= ldf_pkg::LVL_MAX;
      if (state == ldf_pkg::ST_PROGDIV && drsp.done) begin
        if (progneg && pnum != '0) prog <= '0;
        else if (drsp.quo > ldf_pkg::div_word_t'(ldf_pkg::LVL_MAX)) prog <= ldf_pkg::LVL_MAX;
        else prog <= drsp.quo[6:0];
      end
    end
  end

  always_comb begin
    in_stall = state != ldf_pkg::ST_IDLE;
    out_valid = state == ldf_pkg::ST_OUT;
    out_data.level_out = cur;
    out_data.is_on = cur != '0;
    out_data.is_fading = fading;
    out_data.fade_progress = prog;
  end

  `LDF_ASSERT(a_out_only_state, clk, rst, out_valid |-> in_stall)
  `LDF_ASSERT(a_level_max, clk, rst, out_valid |-> cur <= ldf_pkg::LVL_MAX)
  `LDF_ASSERT(a_hold, clk, rst, (out_valid && out_stall) |=> out_valid && $stable(cur))
  `LDF_ASSERT_NR(a_reset, clk, rst |=> !out_valid)
endmodule
